### sv/prime_sieve_table_defines.svh
// ----------------------------------------------------------------------------
// prime_sieve_table_defines
// Assertion macros used by the checker of the prime sieve table.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_TABLE_DEFINES_SVH
`define PRIME_SIEVE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define PST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Field widths, command and status codes and the result type of the
// prime sieve table.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int LIMIT_W  = 11;
   localparam int NUM_W    = 11;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // command codes
   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ABOVE     = 2'd2;

   typedef struct packed {
      logic                is_prime;
      logic [COUNT_W-1:0]  prime_total;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

### sv/pst_ifs.sv
// ----------------------------------------------------------------------------
// pst_ifs
// Valid/ready channels of the prime sieve table: request, response and
// limit register write.
// ----------------------------------------------------------------------------
interface pst_req_if;
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [pst_pkg::NUM_W-1:0] query_number;

   modport source (output valid, output command, output query_number, input ready);
   modport sink   (input valid, input command, input query_number, output ready);
endinterface

interface pst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         is_prime;
   logic [pst_pkg::COUNT_W-1:0]  prime_total;
   logic [pst_pkg::STATUS_W-1:0] status;

   modport source (output valid, output is_prime, output prime_total, output status,
                   input ready);
   modport sink   (input valid, input is_prime, input prime_total, input status,
                   output ready);
endinterface

interface pst_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pst_pkg::LIMIT_W-1:0] sieve_limit;

   modport source (output valid, output sieve_limit, input ready);
   modport sink   (input valid, input sieve_limit, output ready);
endinterface

### sv/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1025,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pst_engine.sv
// ----------------------------------------------------------------------------
// pst_engine
// Sequencer of the prime sieve table: runs the sieve over the composite
// map in memory and answers queries with one map read each, none for a rejected query.
// ----------------------------------------------------------------------------
module pst_engine #(
   parameter int MAX_LIMIT = 1024,
   localparam int AW = $clog2(MAX_LIMIT + 1),
   localparam int CW = ((AW > pst_pkg::NUM_W) ? AW : pst_pkg::NUM_W) + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   pst_req_if.sink                     req,
   input  logic [pst_pkg::LIMIT_W-1:0] limit_value,
   input  logic                        limit_write,
   input  logic                        out_free,
   output pst_pkg::result_type         result,
   output logic                        ram_we,
   output logic [AW-1:0]               ram_waddr,
   output logic                        ram_wdata,
   output logic                        ram_re,
   output logic [AW-1:0]               ram_raddr,
   input  logic                        ram_rdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_QWAIT  = 3'd1;
   localparam logic [2:0] S_CLEAR  = 3'd2;
   localparam logic [2:0] S_PREAD  = 3'd3;
   localparam logic [2:0] S_PCHECK = 3'd4;
   localparam logic [2:0] S_MARK   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [CW-1:0] LIM_MAX = CW'(MAX_LIMIT);

   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 m_ff, m_in;
   logic [CW-1:0]                 p_ff, p_in;
   logic [pst_pkg::STATUS_W-1:0]  qstat_ff, qstat_in;
   logic                          built_ff, built_in;
   logic [pst_pkg::COUNT_W-1:0]   count_ff, count_in;

   logic [CW-1:0] lim;
   logic [CW-1:0] qnum;
   logic          accept;

   // saturate the limit to the map size
   assign lim    = (CW'(limit_value) > LIM_MAX) ? LIM_MAX : CW'(limit_value);
   assign qnum   = CW'(req.query_number);
   assign accept = req.valid && req.ready;

   assign req.ready = (state_ff == S_IDLE) && !reset;

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      p_in      = p_ff;
      qstat_in  = qstat_ff;
      built_in  = built_ff;
      count_in  = count_ff;
      ram_we    = 1'b0;
      ram_waddr = m_ff[AW-1:0];
      ram_wdata = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = p_ff[AW-1:0];
      result.valid               = 1'b0;
      result.payload.is_prime    = 1'b0;
      result.payload.prime_total = count_ff;
      result.payload.status      = pst_pkg::STAT_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.command == pst_pkg::CMD_BUILD) begin
                  m_in     = '0;
                  count_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  if (!built_ff) begin
                     qstat_in = pst_pkg::STAT_NOT_BUILT;
                  end else if (qnum > lim) begin
                     qstat_in = pst_pkg::STAT_ABOVE;
                  end else begin
                     qstat_in  = pst_pkg::STAT_OK;
                     ram_re    = 1'b1;
                     ram_raddr = qnum[AW-1:0];
                  end
                  state_in = S_QWAIT;
               end
            end
         end
         S_QWAIT: begin
            // map bit is back; hold it until the output register frees up
            result.valid            = 1'b1;
            result.payload.is_prime = (qstat_ff == pst_pkg::STAT_OK) && !ram_rdata;
            result.payload.status   = qstat_ff;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            // zero and one are not prime, everything else starts unmarked
            ram_we    = 1'b1;
            ram_wdata = (m_ff < CW'(2));
            if (m_ff >= lim) begin
               p_in     = CW'(2);
               state_in = S_PREAD;
            end else begin
               m_in = m_ff + CW'(1);
            end
         end
         S_PREAD: begin
            if (p_ff > lim) begin
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_PCHECK;
            end
         end
         S_PCHECK: begin
            if (!ram_rdata) begin
               count_in = count_ff + pst_pkg::COUNT_W'(1);
               m_in     = p_ff + p_ff;
               state_in = S_MARK;
            end else begin
               p_in     = p_ff + CW'(1);
               state_in = S_PREAD;
            end
         end
         S_MARK: begin
            // strike multiples of p by repeated addition
            if (m_ff > lim) begin
               p_in     = p_ff + CW'(1);
               state_in = S_PREAD;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = 1'b1;
               m_in      = m_ff + p_ff;
            end
         end
         S_DONE: begin
            result.valid = 1'b1;
            if (out_free) begin
               built_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new limit invalidates the map
      if (limit_write) begin
         built_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         built_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      p_ff     <= p_in;
      qstat_ff <= qstat_in;
   end

endmodule

### sv/prime_sieve_table.sv
// ----------------------------------------------------------------------------
// prime_sieve_table
// Prime lookup table over 0..limit, filled by the Sieve of Eratosthenes.
// ----------------------------------------------------------------------------
// Channels: req carries command and query_number, rsp returns is_prime,
// prime_total and status, csr writes sieve_limit (ready out of reset; the
// user must see that it is written only while the block is idle, which the
// block does not enforce). A write to sieve_limit marks the table as not
// built. Every request gives exactly one response item. A query passes the
// registered read of the composite map and then the output register before
// its response item appears. One item is worked on at a time: a new request
// is accepted only once the sequencer is back in idle. A build walks the map
// in the memory: it clears entries 0..lim, then reads and tests each number
// 2..lim in turn and, for each prime found, strikes its multiples one write
// at a time through the single write port of the map.
// The output register lets the next request be accepted while a response
// waits; a stalled receiver holds the result and, once the next item is done,
// the sequencer as well.
// Reset clears the control state: the table reads as not built, the prime
// count is zero and the limit is 1024. The map memory is not cleared; a build
// writes every entry a query may read.
// ----------------------------------------------------------------------------
module prime_sieve_table #(
   parameter int MAX_LIMIT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   pst_req_if.sink    req,
   pst_rsp_if.source  rsp,
   pst_csr_if.sink    csr
);

   localparam int AW = $clog2(MAX_LIMIT + 1);

   logic [pst_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pst_pkg::rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic                csr_write;
   logic                out_free;
   pst_pkg::result_type result;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic                ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic                ram_rdata;

   // limit register
   assign csr.ready = !reset;
   assign csr_write = csr.valid && csr.ready;
   assign limit_in  = csr_write ? csr.sieve_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pst_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // composite map
   pst_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LIMIT + 1)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sieve and query sequencer
   pst_engine #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .limit_value (limit_ff),
      .limit_write (csr_write),
      .out_free    (out_free),
      .result      (result),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata)
   );

   // output register: load a finished item, drop it once taken
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.payload;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.is_prime    = rsp_data_ff.is_prime;
   assign rsp.prime_total = rsp_data_ff.prime_total;
   assign rsp.status      = rsp_data_ff.status;

endmodule

### sv/pst_check.sv
// ----------------------------------------------------------------------------
// pst_check
// Port-level checker of the prime sieve table, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_sieve_table_defines.svh"

module pst_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_is_prime,
   input logic [pst_pkg::COUNT_W-1:0]  rsp_prime_total,
   input logic [pst_pkg::STATUS_W-1:0] rsp_status
);

   // a stalled response item holds
   `PST_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_prime) && $stable(rsp_prime_total) && $stable(rsp_status), "response changed while stalled")

   // status is one of the defined codes
   `PST_ASSERT_IMP(a_status_code, rsp_valid, rsp_status == pst_pkg::STAT_OK || rsp_status == pst_pkg::STAT_NOT_BUILT || rsp_status == pst_pkg::STAT_ABOVE, "undefined status code")

   // an error answer never claims a prime
   `PST_ASSERT_IMP(a_err_not_prime, rsp_valid && rsp_status != pst_pkg::STAT_OK, !rsp_is_prime, "prime reported with error status")

   // a prime answer needs a build that found primes
   `PST_ASSERT_IMP(a_prime_counted, rsp_valid && rsp_is_prime, rsp_prime_total != '0, "prime reported with zero prime count")

endmodule

bind prime_sieve_table pst_check u_pst_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_is_prime    (rsp.is_prime),
   .rsp_prime_total (rsp.prime_total),
   .rsp_status      (rsp.status)
);
